/* src/tlvs_pkg.sv */
// shared constants, types and byte tables of the tlv serializer
`default_nettype none

package tlvs_pkg;

	localparam int LENGTH_WIDTH_DEF = 16;
	localparam int LEN_W_MAX = 16;
	localparam int RUN_IDX_W = 5;
	localparam int ADDR_W = 3;
	localparam int DATA_W = 32;

	localparam logic CMD_START = 1'b0;
	localparam logic CMD_DATA = 1'b1;

	localparam logic REG_XOR_KEY = 1'b0;
	localparam logic [7:0] XOR_KEY_RESET = 8'd42;

	localparam logic [7:0] TAG_CONTENT = 8'ha2;
	localparam logic [7:0] TAG_STR_SHORT = 8'haa;
	localparam logic [7:0] TAG_STR_LONG = 8'hab;
	localparam logic [7:0] TAG_ARR_SHORT = 8'hac;
	localparam logic [7:0] TAG_ARR_LONG = 8'had;

	localparam logic [7:0] HDR_BYTES [16] = '{
		8'hae, 8'h01, 8'haa, 8'h04, 8'h46, 8'h69, 8'h6c, 8'h65,
		8'hae, 8'h02, 8'haa, 8'h04, 8'h6e, 8'h61, 8'h6d, 8'h65
	};
	localparam logic [7:0] KEY_BYTES [7] = '{
		8'haa, 8'h05, 8'h62, 8'h79, 8'h74, 8'h65, 8'h73
	};

	typedef enum logic [1:0] {
		RUN_START,
		RUN_NAME,
		RUN_CONTENT
	} run_kind_t;

	// one input item's worth of output bytes, walked by the emitter
	typedef struct packed {
		run_kind_t kind;
		logic [LEN_W_MAX-1:0] name_len;
		logic [LEN_W_MAX-1:0] content_len;
		logic [7:0] data;
		logic eom;
		logic [RUN_IDX_W-1:0] last_idx;
	} run_t;

	// k-th byte of a length header, short form when the length fits in a byte
	function automatic logic [7:0] len_hdr_byte(input logic [7:0] short_tag,
			input logic [7:0] long_tag, input logic [LEN_W_MAX-1:0] len,
			input logic [1:0] k);
		logic [7:0] b;
		if (len[LEN_W_MAX-1:8] == '0) begin
			b = (k == 2'd0) ? short_tag : len[7:0];
		end else begin
			case (k)
				2'd0: b = long_tag;
				2'd1: b = len[15:8];
				default: b = len[7:0];
			endcase
		end
		return b;
	endfunction

endpackage

`default_nettype wire

/* src/tlvs_in_if.sv */
// input channel: command words with lengths or a data byte
`default_nettype none

interface tlvs_in_if;
	import tlvs_pkg::*;

	logic valid;
	logic ready;
	logic cmd;
	logic [15:0] name_length;
	logic [15:0] content_length;
	logic [7:0] data_byte;

	modport source (output valid, cmd, name_length, content_length, data_byte, input ready);
	modport sink (input valid, cmd, name_length, content_length, data_byte, output ready);
endinterface

`default_nettype wire

/* src/tlvs_out_if.sv */
// output channel: one serialized byte per word
`default_nettype none

interface tlvs_out_if;
	logic valid;
	logic ready;
	logic [7:0] out_byte;
	logic last_of_run;
	logic end_of_message;

	modport source (output valid, out_byte, last_of_run, end_of_message, input ready);
	modport sink (input valid, out_byte, last_of_run, end_of_message, output ready);
endinterface

`default_nettype wire

/* src/tlvs_apb_regs.sv */
// apb register block holding the scrambling key
`default_nettype none

module tlvs_apb_regs (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic psel,
	input wire logic penable,
	input wire logic pwrite,
	input wire logic [tlvs_pkg::ADDR_W-1:0] paddr,
	input wire logic [tlvs_pkg::DATA_W-1:0] pwdata,
	output logic [tlvs_pkg::DATA_W-1:0] prdata,
	output logic pready,
	output logic [7:0] xor_key
);
	import tlvs_pkg::*;

	logic [7:0] xor_key_q;
	logic wr_en;

	assign pready = 1'b1;
	assign wr_en = psel && penable && pwrite && pready && (paddr[2] == REG_XOR_KEY);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			xor_key_q <= XOR_KEY_RESET;
		end else if (wr_en) begin
			xor_key_q <= pwdata[7:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[2] == REG_XOR_KEY) begin
			prdata = DATA_W'(xor_key_q);
		end
	end

	assign xor_key = xor_key_q;
endmodule

`default_nettype wire

/* src/tlvs_ctrl.sv */
// message state and input register: turns each word into a byte run
`default_nettype none

module tlvs_ctrl #(
	parameter int LENGTH_WIDTH = tlvs_pkg::LENGTH_WIDTH_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	tlvs_in_if.sink in_ch,
	input wire logic take,
	output logic run_valid,
	output tlvs_pkg::run_t run
);
	import tlvs_pkg::*;

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_NAME,
		PH_CONTENT
	} phase_t;

	phase_t phase_q, phase_d;
	logic [LENGTH_WIDTH-1:0] rem_q, rem_d;
	logic [LENGTH_WIDTH-1:0] pend_q, pend_d;
	logic valid_s1;
	run_t run_s1, run_d;
	logic has_run;
	logic accept;
	logic bytes_part;
	logic [LENGTH_WIDTH-1:0] nl, cl, rem_dec;
	logic [RUN_IDX_W-1:0] nhl, chl, bp_len;

	assign in_ch.ready = !valid_s1 || take;
	assign accept = in_ch.valid && in_ch.ready;

	assign nl = in_ch.name_length[LENGTH_WIDTH-1:0];
	assign cl = in_ch.content_length[LENGTH_WIDTH-1:0];
	assign rem_dec = rem_q - LENGTH_WIDTH'(1);

	always_comb begin
		phase_d = phase_q;
		rem_d = rem_q;
		pend_d = pend_q;
		has_run = 1'b0;
		bytes_part = 1'b0;
		run_d.kind = RUN_CONTENT;
		run_d.name_len = LEN_W_MAX'(nl);
		run_d.content_len = LEN_W_MAX'(pend_q);
		run_d.data = in_ch.data_byte;
		run_d.eom = 1'b0;
		if (in_ch.cmd == CMD_START) begin
			has_run = 1'b1;
			run_d.kind = RUN_START;
			run_d.content_len = LEN_W_MAX'(cl);
			pend_d = cl;
			if (nl == '0) begin
				bytes_part = 1'b1;
			end else begin
				phase_d = PH_NAME;
				rem_d = nl;
			end
		end else begin
			case (phase_q)
				PH_NAME: begin
					has_run = 1'b1;
					run_d.kind = RUN_NAME;
					rem_d = rem_dec;
					bytes_part = (rem_dec == '0);
				end
				PH_CONTENT: begin
					has_run = 1'b1;
					run_d.kind = RUN_CONTENT;
					rem_d = rem_dec;
					if (rem_dec == '0) begin
						phase_d = PH_IDLE;
						run_d.eom = 1'b1;
					end
				end
				default: begin
					phase_d = PH_IDLE;
				end
			endcase
		end
		// "bytes" key and array header close the name section
		if (bytes_part) begin
			if (run_d.content_len == '0) begin
				phase_d = PH_IDLE;
				rem_d = '0;
				run_d.eom = 1'b1;
			end else begin
				phase_d = PH_CONTENT;
				rem_d = LENGTH_WIDTH'(run_d.content_len);
			end
		end
		// run length, last index = count - 1
		nhl = (run_d.name_len[LEN_W_MAX-1:8] != '0) ? RUN_IDX_W'(3) : RUN_IDX_W'(2);
		chl = (run_d.content_len[LEN_W_MAX-1:8] != '0) ? RUN_IDX_W'(3) : RUN_IDX_W'(2);
		bp_len = bytes_part ? (RUN_IDX_W'(7) + chl) : '0;
		case (run_d.kind)
			RUN_START: run_d.last_idx = RUN_IDX_W'(15) + nhl + bp_len;
			RUN_NAME: run_d.last_idx = bp_len;
			default: run_d.last_idx = RUN_IDX_W'(1);
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			rem_q <= '0;
			pend_q <= '0;
			valid_s1 <= 1'b0;
		end else begin
			if (accept) begin
				phase_q <= phase_d;
				rem_q <= rem_d;
				pend_q <= pend_d;
			end
			if (accept && has_run) begin
				valid_s1 <= 1'b1;
			end else if (take) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && has_run) begin
			run_s1 <= run_d;
		end
	end

	assign run_valid = valid_s1;
	assign run = run_s1;

`ifndef ASSERT_OFF
	a_idle_no_rem: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_IDLE |-> rem_q == '0)
		else $error("idle with bytes outstanding");
	a_open_has_rem: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q != PH_IDLE |-> rem_q != '0)
		else $error("open message with zero bytes left");
`endif
endmodule

`default_nettype wire

/* src/tlvs_emit.sv */
// walks the current byte run and fills the output register
`default_nettype none

module tlvs_emit (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic run_valid,
	input wire tlvs_pkg::run_t run,
	input wire logic [7:0] xor_key,
	output logic take,
	tlvs_out_if.source out_ch
);
	import tlvs_pkg::*;

	logic [RUN_IDX_W-1:0] pos_q;
	logic out_valid_q;
	logic [7:0] byte_q;
	logic last_q;
	logic eom_q;
	logic fire;
	logic at_last;
	logic [RUN_IDX_W-1:0] base, p_bp, p_len;
	logic [7:0] bp_byte, cur_byte;

	assign fire = run_valid && (!out_valid_q || out_ch.ready);
	assign at_last = (pos_q == run.last_idx);
	assign take = fire && at_last;

	always_comb begin
		base = (run.name_len[LEN_W_MAX-1:8] != '0) ? RUN_IDX_W'(19) : RUN_IDX_W'(18);
		p_bp = (run.kind == RUN_START) ? (pos_q - base) : (pos_q - RUN_IDX_W'(1));
		p_len = p_bp - RUN_IDX_W'(7);
		if (p_bp < RUN_IDX_W'(7)) begin
			bp_byte = KEY_BYTES[p_bp[2:0]];
		end else begin
			bp_byte = len_hdr_byte(TAG_ARR_SHORT, TAG_ARR_LONG, run.content_len, p_len[1:0]);
		end
		case (run.kind)
			RUN_START: begin
				if (pos_q < RUN_IDX_W'(16)) begin
					cur_byte = HDR_BYTES[pos_q[3:0]];
				end else if (pos_q < base) begin
					cur_byte = len_hdr_byte(TAG_STR_SHORT, TAG_STR_LONG, run.name_len,
						pos_q[1:0]);
				end else begin
					cur_byte = bp_byte;
				end
			end
			RUN_NAME: cur_byte = (pos_q == '0) ? run.data : bp_byte;
			default: cur_byte = (pos_q == '0) ? TAG_CONTENT : run.data;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (fire) begin
				pos_q <= at_last ? '0 : pos_q + RUN_IDX_W'(1);
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			byte_q <= cur_byte ^ xor_key;
			last_q <= at_last;
			eom_q <= at_last && run.eom;
		end
	end

	assign out_ch.valid = out_valid_q;
	assign out_ch.out_byte = byte_q;
	assign out_ch.last_of_run = last_q;
	assign out_ch.end_of_message = eom_q;

`ifndef ASSERT_OFF
	a_pos_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		run_valid |-> pos_q <= run.last_idx)
		else $error("byte index past end of run");
	a_eom_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && eom_q |-> last_q)
		else $error("message end not on last byte of run");
	a_pos_rewinds: assert property (@(posedge clk) disable iff (!arst_n)
		take |=> pos_q == '0)
		else $error("byte index not rewound after run");
`endif
endmodule

`default_nettype wire

/* src/file_message_tlv_serializer_core.sv */
// top level of the tlv file message serializer
// the input word is registered into the run register, then each of its bytes into the output register
// throughput: one output byte per cycle while the receiver is ready; a content word gives
// 2 bytes, a name word 1 (or 10 to 11 on the last name byte), a start word 18 to 29, set by the emitter walk
// a new input word is taken in the cycle the previous run emits its last byte
// reset: arst_n clears message state, run and output valids; key returns to 42
`default_nettype none

module file_message_tlv_serializer_core #(
	parameter int LENGTH_WIDTH = tlvs_pkg::LENGTH_WIDTH_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	tlvs_in_if.sink in_ch,
	tlvs_out_if.source out_ch,
	input wire logic psel,
	input wire logic penable,
	input wire logic pwrite,
	input wire logic [tlvs_pkg::ADDR_W-1:0] paddr,
	input wire logic [tlvs_pkg::DATA_W-1:0] pwdata,
	output logic [tlvs_pkg::DATA_W-1:0] prdata,
	output logic pready
);
	import tlvs_pkg::*;

	logic [7:0] xor_key;
	logic take;
	logic run_valid;
	run_t run;

	tlvs_apb_regs u_regs (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.xor_key(xor_key)
	);

	tlvs_ctrl #(
		.LENGTH_WIDTH(LENGTH_WIDTH)
	) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.take(take),
		.run_valid(run_valid),
		.run(run)
	);

	tlvs_emit u_emit (
		.clk(clk),
		.arst_n(arst_n),
		.run_valid(run_valid),
		.run(run),
		.xor_key(xor_key),
		.take(take),
		.out_ch(out_ch)
	);
endmodule

`default_nettype wire

/* bench/tb.sv */
// testbench of the tlv file message serializer: byte-stream predictor, random traffic, apb key writes
`timescale 1ns / 100ps

module tb;
	import tlvs_pkg::*;

	localparam int LEN_W = LENGTH_WIDTH_DEF;
	localparam logic [15:0] LEN_MASK = 16'((32'd1 << LEN_W) - 1);
	localparam logic [ADDR_W-1:0] XOR_KEY_ADDR = ADDR_W'(4 * REG_XOR_KEY);
	localparam logic [7:0] TAG_MAP = 8'hae;
	localparam int SETTLE_CYCLES = 40;
	localparam int HOLD_CYCLES = 400;
	localparam int STALL_LIMIT = 4000;

	typedef enum logic [1:0] {
		MSG_IDLE,
		MSG_NAME,
		MSG_CONTENT
	} msg_phase_t;

	typedef enum int {
		RX_STEADY,
		RX_COIN,
		RX_SPARSE,
		RX_MOSTLY
	} rx_mode_t;

	typedef struct {
		logic [7:0] value;
		logic last_of_run;
		logic end_of_message;
	} tlv_byte_t;

	class tlv_byte_predictor;
		tlv_byte_t bytes_due[$];
		tlv_byte_t run[$];
		logic [7:0] key;
		msg_phase_t phase;
		logic [15:0] remaining;
		logic [15:0] content_len;
		int errors;

		function new();
			key = XOR_KEY_RESET;
			phase = MSG_IDLE;
			remaining = '0;
			content_len = '0;
			errors = 0;
		endfunction

		function void emit(logic [7:0] b);
			tlv_byte_t w;
			w.value = b ^ key;
			w.last_of_run = 1'b0;
			w.end_of_message = 1'b0;
			run.insert(run.size(), w);
		endfunction

		function void emit_key(string s);
			emit(TAG_STR_SHORT);
			emit(8'(s.len()));
			for (int i = 0; i < s.len(); i++)
				emit(s[i]);
		endfunction

		function void emit_len(logic [7:0] short_tag, logic [7:0] long_tag, logic [15:0] len);
			if (len < 16'd256) begin
				emit(short_tag);
				emit(len[7:0]);
			end else begin
				emit(long_tag);
				emit(len[15:8]);
				emit(len[7:0]);
			end
		endfunction

		// "bytes" key and array header close the name part
		function void emit_content_head();
			emit_key("bytes");
			emit_len(TAG_ARR_SHORT, TAG_ARR_LONG, content_len);
			if (content_len == '0) begin
				run[run.size() - 1].end_of_message = 1'b1;
				phase = MSG_IDLE;
				remaining = '0;
			end else begin
				phase = MSG_CONTENT;
				remaining = content_len;
			end
		endfunction

		function void take_word(logic cmd, logic [15:0] name_len, logic [15:0] cont_len,
				logic [7:0] data);
			logic [15:0] nl;
			run.delete();
			if (cmd == CMD_START) begin
				// a start also abandons any open message
				nl = name_len & LEN_MASK;
				content_len = cont_len & LEN_MASK;
				emit(TAG_MAP);
				emit(8'd1);
				emit_key("File");
				emit(TAG_MAP);
				emit(8'd2);
				emit_key("name");
				emit_len(TAG_STR_SHORT, TAG_STR_LONG, nl);
				if (nl == '0) begin
					emit_content_head();
				end else begin
					phase = MSG_NAME;
					remaining = nl;
				end
			end else if (phase == MSG_NAME) begin
				emit(data);
				remaining = remaining - 16'd1;
				if (remaining == '0)
					emit_content_head();
			end else if (phase == MSG_CONTENT) begin
				emit(TAG_CONTENT);
				emit(data);
				remaining = remaining - 16'd1;
				if (remaining == '0) begin
					run[run.size() - 1].end_of_message = 1'b1;
					phase = MSG_IDLE;
				end
			end
			if (run.size() > 0) begin
				run[run.size() - 1].last_of_run = 1'b1;
				foreach (run[i])
					bytes_due.insert(bytes_due.size(), run[i]);
			end
		endfunction

		task report(string msg);
			errors++;
			if (errors <= 50)
				$display("%0t: %s", $time, msg);
		endtask

		task check_byte(logic [7:0] value, logic last, logic eom);
			tlv_byte_t w;
			if (bytes_due.size() == 0) begin
				report($sformatf("word %02h with nothing expected", value));
			end else begin
				w = bytes_due.pop_front();
				if (value !== w.value)
					report($sformatf("out_byte %02h, expected %02h", value, w.value));
				if (last !== w.last_of_run)
					report($sformatf("last_of_run %b, expected %b on byte %02h",
						last, w.last_of_run, w.value));
				if (eom !== w.end_of_message)
					report($sformatf("end_of_message %b, expected %b on byte %02h",
						eom, w.end_of_message, w.value));
			end
		endtask
	endclass

	logic clk;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;
	logic pready;

	tlvs_in_if in_ch();
	tlvs_out_if out_ch();

	file_message_tlv_serializer_core #(
		.LENGTH_WIDTH(LEN_W)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	tlv_byte_predictor predictor;
	int burst_left;
	bit eager;
	bit hold_req;
	int quiet_cycles;

	initial clk = 1'b0;
	always #10 clk = ~clk;

	task automatic send_word(input logic cmd, input logic [15:0] name_len,
			input logic [15:0] cont_len, input logic [7:0] data);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			gap = (eager || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				in_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_ch.valid <= 1'b1;
		in_ch.cmd <= cmd;
		in_ch.name_length <= name_len;
		in_ch.content_length <= cont_len;
		in_ch.data_byte <= data;
		do @(posedge clk); while (in_ch.ready !== 1'b1);
		predictor.take_word(cmd, name_len, cont_len, data);
	endtask

	task automatic send_start(input logic [15:0] name_len, input logic [15:0] cont_len);
		send_word(CMD_START, name_len, cont_len, 8'($urandom));
	endtask

	task automatic send_data(input logic [7:0] data);
		send_word(CMD_DATA, 16'($urandom), 16'($urandom), data);
	endtask

	// stop offering words and wait until every expected byte is out
	task automatic drain(input int settle);
		in_ch.valid <= 1'b0;
		burst_left = 0;
		do @(posedge clk); while (predictor.bytes_due.size() != 0);
		repeat (settle) @(posedge clk);
	endtask

	task automatic write_key(input logic [7:0] k);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= XOR_KEY_ADDR;
		pwdata <= DATA_W'(k);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		predictor.key = k;
	endtask

	task automatic random_traffic(input int items);
		int sent;
		int pick;
		int n;
		int nl;
		int cl;
		sent = 0;
		while (sent < items) begin
			pick = $urandom_range(0, 99);
			if (pick < 6) begin
				// stray byte, dropped when no message is open
				send_data(8'($urandom));
				sent += 1;
			end else if (pick < 18) begin
				// any lengths, usually cut short by the next start
				send_start(16'($urandom), 16'($urandom));
				n = $urandom_range(0, 3);
				repeat (n) send_data(8'($urandom));
				sent += n + 1;
			end else begin
				nl = ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 5);
				cl = ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 6);
				send_start(16'(nl), 16'(cl));
				repeat (nl + cl) send_data(8'($urandom));
				sent += 1 + nl + cl;
			end
		end
	endtask

	// receiver: ready pattern changes now and then, long hold-off on request
	initial begin : receiver
		rx_mode_t mode;
		int mode_left;
		int hold_left;
		int tick;
		out_ch.ready <= 1'b0;
		mode = RX_STEADY;
		mode_left = 0;
		hold_left = 0;
		tick = 0;
		forever begin
			@(posedge clk);
			tick++;
			if (hold_req && hold_left == 0) begin
				hold_req = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (mode_left == 0) begin
				mode = rx_mode_t'($urandom_range(0, 3));
				mode_left = $urandom_range(40, 160);
			end
			mode_left--;
			if (hold_left > 0) begin
				hold_left--;
				out_ch.ready <= 1'b0;
			end else begin
				case (mode)
					RX_STEADY: out_ch.ready <= 1'b1;
					RX_COIN: out_ch.ready <= 1'($urandom_range(0, 1));
					RX_SPARSE: out_ch.ready <= (tick % 4 == 0);
					default: out_ch.ready <= ($urandom_range(0, 7) != 0);
				endcase
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
			predictor.check_byte(out_ch.out_byte, out_ch.last_of_run, out_ch.end_of_message);
	end

	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin : stimulus
		predictor = new();
		burst_left = 0;
		eager = 1'b0;
		hold_req = 1'b0;
		quiet_cycles = 0;
		arst_n <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		in_ch.valid <= 1'b0;
		in_ch.cmd <= CMD_START;
		in_ch.name_length <= '0;
		in_ch.content_length <= '0;
		in_ch.data_byte <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: ignored data, empty parts, short and long headers, abandoned messages
		send_data(8'hff);
		send_start(16'd0, 16'd0);
		send_start(16'd1, 16'd1);
		send_data(8'h00);
		send_data(8'hff);
		send_start(16'd255, 16'd255);
		send_data(8'h5a);
		send_start(16'd256, 16'd256);
		send_data(8'ha5);
		send_start(16'd0, 16'd300);
		send_data(8'h00);
		send_data(8'hff);
		send_start(16'hffff, 16'hffff);
		send_data(8'h3c);
		send_start(16'd2, 16'd0);
		send_data(8'h81);
		send_data(8'h7e);
		send_data(8'h00);
		send_start(16'd0, 16'd1);
		send_data(8'hc3);

		drain(SETTLE_CYCLES);
		write_key(8'h00);
		random_traffic(110);

		drain(SETTLE_CYCLES);
		write_key(8'hff);
		// receiver holds off while a long message floods the input
		eager = 1'b1;
		hold_req = 1'b1;
		send_start(16'd3, 16'd24);
		repeat (27) send_data(8'($urandom));
		eager = 1'b0;
		random_traffic(80);

		drain(SETTLE_CYCLES);
		write_key(8'($urandom));
		random_traffic(60);
		drain(0);
		random_traffic(60);

		drain(SETTLE_CYCLES);
		if (predictor.errors == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
